### rtl/dse_pkg.sv
package dse_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int LENGTH_BITS_DEF = 12;

  localparam int PAT_W   = 64;
  localparam int PLEN_W  = 4;
  localparam int CHAR_W  = 8;
  localparam int SPAN_W  = 12;
  localparam int PIDX_W  = 3;

  // configuration register indexes
  localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] REG_END_CHAR       = 2'd2;
  localparam logic [1:0] REG_MAX_SPAN       = 2'd3;

  localparam logic [PAT_W-1:0]  PATTERN_BYTES_RST  = '0;
  localparam logic [PLEN_W-1:0] PATTERN_LENGTH_RST = 4'd1;
  localparam logic [CHAR_W-1:0] END_CHAR_RST       = 8'd34;
  localparam logic [SPAN_W-1:0] MAX_SPAN_RST       = 12'd4095;

  localparam logic [CHAR_W-1:0] TEXT_END = 8'h00;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // pending results of one input word
  typedef struct packed {
    logic              active;
    logic              is_pat;
    logic [CHAR_W-1:0] data;
    logic              close;
    logic              ovf;
    logic [PLEN_W-1:0] len;
  } burst_t;

endpackage

### rtl/dse_text_if.sv
interface dse_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_last;

  modport source (output valid, output text_byte, output text_last, input ready);
  modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

### rtl/dse_span_if.sv
interface dse_span_if;
  logic       valid;
  logic       ready;
  logic [7:0] span_byte;
  logic       span_first;
  logic       span_final;
  logic       overflow;
  logic       run_last;

  modport source (output valid, output span_byte, output span_first, output span_final,
                  output overflow, output run_last, input ready);
  modport sink   (input valid, input span_byte, input span_first, input span_final,
                  input overflow, input run_last, output ready);
endinterface

### rtl/dse_cell.sv
module dse_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  dse_pkg::cell_ctl_t      ctl,
  input  logic [7:0]              in_byte,
  input  logic                    in_valid,
  input  logic [7:0]              pat_byte,
  input  logic                    care,
  output logic [7:0]              out_byte,
  output logic                    out_valid,
  output logic                    hit
);

  logic [7:0] data;
  logic       valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= in_byte;
    end
  end

  // compare the byte about to enter this cell
  assign hit       = !care || (in_valid && (in_byte == pat_byte));
  assign out_byte  = data;
  assign out_valid = valid;

endmodule

### rtl/dse_emit.sv
module dse_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_en,
  input  dse_pkg::burst_t              load,
  input  logic [dse_pkg::PAT_W-1:0]    pattern,
  output logic                         take,
  dse_span_if.source                   out
);

  dse_pkg::burst_t              burst;
  logic [dse_pkg::PIDX_W-1:0]   idx;
  logic                         at_last;
  logic                         fire;

  assign at_last = !burst.is_pat ||
                   ({1'b0, idx} == (burst.len - dse_pkg::PLEN_W'(1)));
  assign fire    = burst.active && out.ready;
  assign take    = !burst.active || (out.ready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      burst <= '0;
      idx   <= '0;
    end else if (load_en) begin
      burst <= load;
      idx   <= '0;
    end else if (fire) begin
      if (at_last) begin
        burst.active <= 1'b0;
      end else begin
        idx <= idx + dse_pkg::PIDX_W'(1);
      end
    end
  end

  always_comb begin
    out.valid      = burst.active;
    out.run_last   = at_last;
    if (burst.is_pat) begin
      out.span_byte  = pattern[{idx, 3'b000} +: 8];
      out.span_first = (idx == '0);
      out.span_final = burst.close && at_last;
      out.overflow   = burst.close && at_last;
    end else begin
      out.span_byte  = burst.data;
      out.span_first = 1'b0;
      out.span_final = burst.close;
      out.overflow   = burst.ovf;
    end
  end

endmodule

### rtl/delimited_span_extractor.sv
// Delimited span extractor.
// Text words enter on the text channel (text_byte, text_last), one per cycle.
// While searching, each byte shifts into a row of compare cells; when the
// newest bytes equal the start pattern, the pattern bytes go out on the span
// channel, then every following byte up to and including end_char. A span
// closes with overflow set when it reaches max_span bytes or the text ends
// (zero byte or text_last) before the delimiter.
// The first result of a word is valid in the cycle after its acceptance.
// Throughput: one text word per cycle; a word that completes a match yields
// the clamped pattern length in result words, which the output register
// drains one per cycle while the receiver is ready, so the next text word is
// taken on the cycle the last of them leaves. A word that yields one or no
// result never holds the input while the receiver is ready.
// A stalled receiver holds the current result; the next text word is taken
// only once all results of the previous word have been taken.
// Reset clears the window, the span state and the output register, and
// restores the registers to their defaults. Configuration is written through
// cfg_we / cfg_index / cfg_data; the user must write it only while the block is idle, which the block does not enforce.
module delimited_span_extractor #(
  parameter int PATTERN_MAX = dse_pkg::PATTERN_MAX_DEF,
  parameter int LENGTH_BITS = dse_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  dse_text_if.sink                    text,
  dse_span_if.source                  span,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [dse_pkg::PAT_W-1:0]   cfg_data
);

  // compare width for span length against the limit
  localparam int CW = (LENGTH_BITS > dse_pkg::SPAN_W) ? LENGTH_BITS : dse_pkg::SPAN_W;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [dse_pkg::PLEN_W-1:0] LEN_MAX = dse_pkg::PLEN_W'(PATTERN_MAX);

  // configuration registers
  logic [dse_pkg::PAT_W-1:0]  pattern_bytes;
  logic [dse_pkg::PLEN_W-1:0] pattern_length;
  logic [dse_pkg::CHAR_W-1:0] end_char;
  logic [dse_pkg::SPAN_W-1:0] max_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= dse_pkg::PATTERN_BYTES_RST;
      pattern_length <= dse_pkg::PATTERN_LENGTH_RST;
      end_char       <= dse_pkg::END_CHAR_RST;
      max_span       <= dse_pkg::MAX_SPAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dse_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        dse_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[dse_pkg::PLEN_W-1:0];
        dse_pkg::REG_END_CHAR:       end_char       <= cfg_data[dse_pkg::CHAR_W-1:0];
        dse_pkg::REG_MAX_SPAN:       max_span       <= cfg_data[dse_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp pattern length to 1..PATTERN_MAX, span limit to the counter range
  logic [dse_pkg::PLEN_W-1:0] eff_len;
  logic [CW-1:0]              limit;

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = dse_pkg::PLEN_W'(1);
    end else if (pattern_length > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = pattern_length;
    end
    if (CW'(max_span) > CW'(CNT_MAX)) begin
      limit = CW'(CNT_MAX);
    end else begin
      limit = CW'(max_span);
    end
  end

  // span state
  logic                   in_span;
  logic [LENGTH_BITS-1:0] span_length;

  logic                   accept;
  logic                   take;
  logic [7:0]             b;
  logic                   last;
  logic                   match;

  assign b      = text.text_byte;
  assign last   = text.text_last;
  assign text.ready = take;
  assign accept = text.valid && take;

  // window: row of compare cells, cell 0 holds the newest byte
  dse_pkg::cell_ctl_t     ctl;
  logic [7:0]             cell_byte  [PATTERN_MAX];
  logic                   cell_valid [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_hit;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [dse_pkg::PLEN_W-1:0] sel;
    logic [7:0]                 in_byte;
    logic                       in_valid;
    logic                       care;

    assign sel  = eff_len - dse_pkg::PLEN_W'(i + 1);
    assign care = dse_pkg::PLEN_W'(i) < eff_len;

    if (i == 0) begin : g_head
      assign in_byte  = b;
      assign in_valid = 1'b1;
    end else begin : g_body
      assign in_byte  = cell_byte[i-1];
      assign in_valid = cell_valid[i-1];
    end

    dse_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .in_byte  (in_byte),
      .in_valid (in_valid),
      .pat_byte (pattern_bytes[{sel[dse_pkg::PIDX_W-1:0], 3'b000} +: 8]),
      .care     (care),
      .out_byte (cell_byte[i]),
      .out_valid(cell_valid[i]),
      .hit      (cell_hit[i])
    );
  end

  assign match = &cell_hit;

  // per-word decisions
  logic [LENGTH_BITS-1:0] span_inc;
  logic                   delim;
  logic                   span_close;
  logic                   pat_close;
  logic                   in_span_next;
  logic [LENGTH_BITS-1:0] span_length_next;
  dse_pkg::burst_t        load;

  always_comb begin
    span_inc   = (span_length == CNT_MAX) ? span_length
                                          : span_length + LENGTH_BITS'(1);
    delim      = (b == end_char);
    span_close = delim || (b == dse_pkg::TEXT_END) || last || (CW'(span_inc) >= limit);
    pat_close  = last || (CW'(eff_len) >= limit);

    ctl.shift        = 1'b0;
    ctl.clear        = 1'b0;
    in_span_next     = in_span;
    span_length_next = span_length;

    load.active = 1'b0;
    load.is_pat = 1'b0;
    load.data   = b;
    load.close  = 1'b0;
    load.ovf    = 1'b0;
    load.len    = eff_len;

    if (accept) begin
      if (in_span) begin
        load.active = 1'b1;
        load.close  = span_close;
        load.ovf    = span_close && !delim;
        if (span_close) begin
          in_span_next     = 1'b0;
          span_length_next = '0;
          ctl.clear        = 1'b1;
        end else begin
          span_length_next = span_inc;
        end
      end else if (b == dse_pkg::TEXT_END) begin
        ctl.clear = 1'b1;
      end else if (match) begin
        // drop the window; the pattern bytes come from the register
        ctl.clear   = 1'b1;
        load.active = 1'b1;
        load.is_pat = 1'b1;
        load.close  = pat_close;
        load.ovf    = pat_close;
        if (pat_close) begin
          span_length_next = '0;
        end else begin
          in_span_next     = 1'b1;
          span_length_next = LENGTH_BITS'(eff_len);
        end
      end else if (last) begin
        ctl.clear = 1'b1;
      end else begin
        ctl.shift = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_span     <= 1'b0;
      span_length <= '0;
    end else begin
      in_span     <= in_span_next;
      span_length <= span_length_next;
    end
  end

  // output register: holds the results of one word and drains them
  dse_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load_en(accept),
    .load   (load),
    .pattern(pattern_bytes),
    .take   (take),
    .out    (span)
  );

endmodule

### dv/tb_delimited_span_extractor.sv
module tb_delimited_span_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import dse_pkg::*;

  // Generous ceiling for a run of a few hundred text words, each with up to
  // eight span words, with stalls on both sides.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SPAN_COUNT_MAX = (1 << LENGTH_BITS_DEF) - 1;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 36;
  localparam int MISMATCH_SHOW  = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
  } text_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              is_first;
    logic              is_final;
    logic              ovf;
    logic              run_end;
  } span_word_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [PAT_W-1:0]  cfg_data;

  dse_text_if text_ch ();
  dse_span_if span_ch ();

  delimited_span_extractor u_top (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch),
    .span      (span_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the configuration registers.
  logic [PAT_W-1:0]  pat_reg;
  logic [PLEN_W-1:0] plen_reg;
  logic [CHAR_W-1:0] end_reg;
  logic [SPAN_W-1:0] limit_reg;

  // Shadow copy of the search window and span state; win_bytes[0] is newest.
  logic [CHAR_W-1:0] win_bytes [PATTERN_MAX_DEF];
  int unsigned       win_fill;
  bit                span_open;
  int unsigned       span_count;

  text_word_t text_pending [$];   // words waiting for the driver
  span_word_t span_expect [$];    // predicted span words, oldest first

  int unsigned words_pushed;
  int unsigned words_issued;
  int unsigned words_taken;
  int unsigned results_taken;
  int unsigned results_seen;
  int unsigned reg_writes;
  int unsigned mismatches;
  int unsigned spans_opened;
  int unsigned overflow_closes;
  int unsigned cycle_count;

  bit          calm_run;          // both sides run without stalls
  bit          send_busy;
  int unsigned send_gap;
  int unsigned recv_gap;
  text_word_t  send_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Span predictor
  // ---------------------------------------------------------------------

  // Out-of-range lengths clamp: zero acts as one, above the window as full.
  function automatic int unsigned clamp_plen(input logic [PLEN_W-1:0] p);
    if (p == 0) return 1;
    if (p > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
    return p;
  endfunction

  function automatic span_word_t make_word(input logic [CHAR_W-1:0] chr, input logic first,
                                           input logic fin, input logic ovf,
                                           input logic run_end);
    span_word_t w;
    w.chr      = chr;
    w.is_first = first;
    w.is_final = fin;
    w.ovf      = ovf;
    w.run_end  = run_end;
    return w;
  endfunction

  function automatic void clear_window();
    for (int j = 0; j < PATTERN_MAX_DEF; j++) win_bytes[j] = '0;
    win_fill = 0;
  endfunction

  function automatic void close_span();
    clear_window();
    span_open  = 1'b0;
    span_count = 0;
  endfunction

  task automatic reset_span_state();
    pat_reg   = PATTERN_BYTES_RST;
    plen_reg  = PATTERN_LENGTH_RST;
    end_reg   = END_CHAR_RST;
    limit_reg = MAX_SPAN_RST;
    close_span();
  endtask

  // Advance the shadow state by one accepted text word and queue the span
  // words it produces.
  task automatic predict_span_words(input logic [CHAR_W-1:0] b, input logic last);
    span_word_t  burst [PATTERN_MAX_DEF];
    int unsigned lim;
    int unsigned len;
    int unsigned n;
    bit          delim;
    bit          closing;
    bit          hit;
    lim = limit_reg;
    n   = 0;
    if (span_open) begin
      // Inside a span: every byte goes out; the counter saturates.
      if (span_count < SPAN_COUNT_MAX) span_count++;
      delim   = (b == end_reg);
      closing = delim || (b == TEXT_END) || last || (span_count >= lim);
      burst[0] = make_word(b, 1'b0, closing, closing && !delim, 1'b0);
      n = 1;
      if (closing) close_span();
    end else if (b == TEXT_END) begin
      // Zero while searching ends the text and is not shifted in.
      clear_window();
    end else begin
      len = clamp_plen(plen_reg);
      for (int j = PATTERN_MAX_DEF - 1; j > 0; j--) win_bytes[j] = win_bytes[j-1];
      win_bytes[0] = b;
      if (win_fill < PATTERN_MAX_DEF) win_fill++;
      hit = (win_fill >= len);
      for (int j = 0; j < len; j++) begin
        if (win_bytes[len-1-j] != pat_reg[8*j +: 8]) hit = 1'b0;
      end
      if (hit) begin
        // Emit the whole pattern; close on it when the text ends here or
        // the pattern already fills the limit.
        span_count = len;
        closing    = last || (span_count >= lim);
        for (int j = 0; j < len; j++) begin
          burst[j] = make_word(pat_reg[8*j +: 8], j == 0, closing && (j == len - 1),
                               closing && (j == len - 1), 1'b0);
        end
        n = len;
        if (closing) begin
          close_span();
        end else begin
          span_open = 1'b1;
          clear_window();
        end
      end else if (last) begin
        clear_window();
      end
    end
    if (n > 0) burst[n-1].run_end = 1'b1;
    for (int k = 0; k < n; k++) span_expect.push_back(burst[k]);
  endtask

  // Compare one accepted span word against the oldest prediction.
  task automatic check_span_word();
    span_word_t got;
    span_word_t want;
    got = make_word(span_ch.span_byte, span_ch.span_first, span_ch.span_final,
                    span_ch.overflow, span_ch.run_last);
    if (got.is_first === 1'b1) spans_opened++;
    if (got.is_final === 1'b1 && got.ovf === 1'b1) overflow_closes++;
    if (span_expect.size() == 0) begin
      mismatches++;
      if (mismatches <= MISMATCH_SHOW)
        $display("[%0t] span word byte %h first %b final %b ovf %b last %b with none predicted",
                 $time, got.chr, got.is_first, got.is_final, got.ovf, got.run_end);
    end else begin
      want = span_expect.pop_front();
      if (got.chr !== want.chr || got.is_first !== want.is_first ||
          got.is_final !== want.is_final || got.ovf !== want.ovf ||
          got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOW) begin
          $display("[%0t] span word %0d: expected byte %h first %b final %b ovf %b last %b",
                   $time, results_taken, want.chr, want.is_first, want.is_final, want.ovf,
                   want.run_end);
          $display("[%0t] span word %0d:      got byte %h first %b final %b ovf %b last %b",
                   $time, results_taken, got.chr, got.is_first, got.is_final, got.ovf,
                   got.run_end);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      // Predict first; any result seen at this edge belongs to an older word.
      if (text_ch.valid && text_ch.ready) begin
        predict_span_words(text_ch.text_byte, text_ch.text_last);
        words_taken++;
      end
      if (span_ch.valid && span_ch.ready) begin
        check_span_word();
        results_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: present pending text words at the falling edge. After each
  // accepted word, draw an idle gap before the next one.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (send_busy && words_taken == words_issued) begin
        send_busy = 1'b0;
        send_gap  = calm_run ? 0 : $urandom_range(0, 4);
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          text_ch.valid <= 1'b0;
        end else if (text_pending.size() != 0) begin
          // Keep valid high across back-to-back words: one assignment only.
          send_word = text_pending.pop_front();
          text_ch.text_byte <= send_word.chr;
          text_ch.text_last <= send_word.last;
          text_ch.valid     <= 1'b1;
          words_issued++;
          send_busy = 1'b1;
        end else begin
          text_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: after each accepted span word, draw an idle gap with ready low.
  always @(negedge clk) begin
    if (!rst) begin
      if (results_taken != results_seen) begin
        results_seen = results_taken;
        recv_gap     = calm_run ? 0 : $urandom_range(0, 4);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        span_ch.ready <= 1'b0;
      end else begin
        span_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_text(input logic [CHAR_W-1:0] chr, input logic last);
    text_word_t w;
    w.chr  = chr;
    w.last = last;
    text_pending.push_back(w);
    words_pushed++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_text(s[i], 1'b0);
  endtask

  // Hold until every word is taken and every span word has come, then let
  // the block settle on a trailing word that produced nothing.
  task automatic wait_idle();
    while (text_pending.size() != 0 || words_taken != words_issued ||
           span_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PAT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PATTERN_BYTES:  pat_reg   = val;
      REG_PATTERN_LENGTH: plen_reg  = val[PLEN_W-1:0];
      REG_END_CHAR:       end_reg   = val[CHAR_W-1:0];
      REG_MAX_SPAN:       limit_reg = val[SPAN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_setting(input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] plen,
                               input logic [CHAR_W-1:0] endc, input logic [SPAN_W-1:0] lim);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, PAT_W'(plen));
    write_reg(REG_END_CHAR, PAT_W'(endc));
    write_reg(REG_MAX_SPAN, PAT_W'(lim));
  endtask

  // Body byte inside a span: never zero, never the delimiter.
  function automatic logic [CHAR_W-1:0] body_byte();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(1, 255)); while (b == end_reg);
    return b;
  endfunction

  // Noise between spans; now and then a zero that ends the text.
  function automatic logic [CHAR_W-1:0] noise_byte();
    if ($urandom_range(0, 15) == 0) return TEXT_END;
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  // Draw a new setting: mostly legal lengths with a small alphabet so that
  // partial and overlapping matches happen, sometimes out-of-range lengths,
  // delimiter extremes and limits at or below the pattern length.
  task automatic pick_random_setting();
    logic [PAT_W-1:0]  pat;
    logic [PLEN_W-1:0] plen;
    logic [CHAR_W-1:0] endc;
    logic [SPAN_W-1:0] lim;
    logic [CHAR_W-1:0] b;
    int unsigned       eff;
    if ($urandom_range(0, 9) == 0)
      plen = $urandom_range(0, 1) ? PLEN_W'(0) : PLEN_W'($urandom_range(9, 15));
    else
      plen = PLEN_W'($urandom_range(1, 8));
    eff = clamp_plen(plen);
    case ($urandom_range(0, 7))
      0:       endc = 8'h00;
      1:       endc = 8'hFF;
      default: endc = CHAR_W'($urandom_range(0, 255));
    endcase
    pat = {$urandom, $urandom};
    for (int j = 0; j < eff; j++) begin
      if ($urandom_range(0, 2) == 0) b = CHAR_W'($urandom_range(1, 255));
      else b = CHAR_W'(8'h41 + $urandom_range(0, 2));
      while (b == endc) b = CHAR_W'($urandom_range(1, 255));
      pat[8*j +: 8] = b;
    end
    case ($urandom_range(0, 5))
      0:       lim = SPAN_W'($urandom_range(0, eff));
      1:       lim = SPAN_W'(SPAN_COUNT_MAX);
      default: lim = SPAN_W'(eff + $urandom_range(1, 20));
    endcase
    write_setting(pat, plen, endc, lim);
  endtask

  // One stretch of text: noise, then usually the pattern and a body that
  // ends in one of the ways a span can close; sometimes a broken start.
  task automatic push_sentence();
    int unsigned len;
    int unsigned noise;
    int unsigned body;
    int unsigned kind;
    int unsigned cut;
    len   = clamp_plen(plen_reg);
    noise = $urandom_range(0, 3);
    repeat (noise) push_text(noise_byte(), $urandom_range(0, 19) == 0);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // broken start: a prefix of the pattern, then a stray byte
      cut = $urandom_range(0, len - 1);
      for (int j = 0; j < cut; j++) push_text(pat_reg[8*j +: 8], 1'b0);
      push_text(noise_byte(), 1'b0);
    end else begin
      // kind 1 ends the text on the final pattern byte
      for (int j = 0; j < len; j++) push_text(pat_reg[8*j +: 8], (j == len - 1) && kind == 1);
      if (kind != 1) begin
        body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
        repeat (body) push_text(body_byte(), 1'b0);
        case (kind)
          2:       push_text(TEXT_END, 1'b0);        // zero byte ends the text
          3:       push_text(body_byte(), 1'b1);     // text ends on a plain byte
          4:       ;                                 // leave the span running
          5:       push_text(end_reg, 1'b1);         // delimiter on the last byte
          default: push_text(end_reg, 1'b0);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned mark;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    text_ch.text_last = 1'b0;
    span_ch.ready     = 1'b0;
    calm_run          = 1'b0;
    send_busy         = 1'b0;
    send_gap          = 0;
    recv_gap          = 0;
    reset_span_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset pattern is a single zero byte, which can never match.
    push_text(8'h22, 1'b0);
    push_text(TEXT_END, 1'b0);
    push_text(8'h5A, 1'b1);
    wait_idle();

    // Two-byte pattern: sliding match, restart right after the delimiter,
    // match on the last byte, zero inside a span, zero while searching,
    // delimiter that is also the last byte.
    write_setting(64'h6261, 4'd2, 8'h22, 12'd4095);
    push_str("xaab\"ab\"");
    push_text("a", 1'b0);
    push_text("b", 1'b1);
    push_str("ab");
    push_text(TEXT_END, 1'b0);
    push_str("a");
    push_text(TEXT_END, 1'b0);
    push_text("b", 1'b1);
    push_str("ab");
    push_text(8'h22, 1'b1);
    wait_idle();

    // Full-width pattern at the top of the byte range, length above the
    // window, zero limit, zero delimiter.
    write_setting({8{8'hFF}}, 4'd15, 8'h00, 12'd0);
    repeat (PATTERN_MAX_DEF) push_text(8'hFF, 1'b0);
    push_text(TEXT_END, 1'b0);
    wait_idle();

    // Length zero acts as one; short limit; delimiter at the top value.
    write_setting(64'h01, 4'd0, 8'hFF, 12'd3);
    push_text(8'h01, 1'b0);
    push_text(TEXT_END, 1'b0);
    push_text(8'h01, 1'b0);
    push_text(8'h02, 1'b0);
    push_text(8'h03, 1'b0);
    push_text(8'h01, 1'b0);
    push_text(8'hFF, 1'b0);
    wait_idle();

    // Pattern holding the delimiter: its bytes never close the span.
    write_setting(64'h6122, 4'd2, 8'h22, 12'd4095);
    push_str("\"ab\"");
    wait_idle();

    // Random settings; halfway through each, hold the sender until the
    // block has drained completely.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm_run = (p == 3);
      pick_random_setting();
      mark = words_pushed;
      while (words_pushed - mark < PHASE_WORDS / 2) push_sentence();
      wait_idle();
      while (words_pushed - mark < PHASE_WORDS) push_sentence();
      wait_idle();
    end
    calm_run = 1'b0;

    $display("Checked %0d span words from %0d text words across %0d register writes.",
             results_taken, words_taken, reg_writes);
    $display("Spans opened: %0d, closed without delimiter: %0d, mismatches: %0d.",
             spans_opened, overflow_closes, mismatches);
    if (mismatches == 0 && span_expect.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles: %0d words queued, %0d span words outstanding.",
             cycle_count, text_pending.size(), span_expect.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
